FILE: hdl/spq_pkg.sv
package spq_pkg;

  // Operation codes carried in the low bits of the input word.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Status codes returned in the low bits of the result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Command broadcast to every cell of the chain for one cycle.
  typedef struct packed {
    logic ins;  // Place a new entry at its sorted position.
    logic pop;  // Shift every entry one place toward the head.
    logic rem;  // Shift entries from the first match onward toward the head.
  } spq_cmd_t;

endpackage

FILE: hdl/spq_cell.sv
module spq_cell
  import spq_pkg::*;
#(
  parameter int IW = 5,
  parameter int PW = 8
) (
  input  logic          clk,
  input  spq_cmd_t      cmd,
  input  logic          occ,        // This slot holds a live entry.
  input  logic [IW-1:0] new_id,
  input  logic [PW-1:0] new_pri,
  // Neighbor toward the head.
  input  logic          cond_prev,
  input  logic          found_prev,
  input  logic [IW-1:0] left_id,
  input  logic [PW-1:0] left_pri,
  // Neighbor toward the tail.
  input  logic [IW-1:0] right_id,
  input  logic [PW-1:0] right_pri,
  output logic          cond,
  output logic          found,
  output logic          first,
  output logic [IW-1:0] id,
  output logic [PW-1:0] pri
);

  logic          match;
  logic [IW-1:0] id_next;
  logic [PW-1:0] pri_next;

  // The new entry goes ahead of this slot when the slot is free or weaker.
  assign cond  = !occ || (new_pri > pri);
  // Remove looks for the match nearest the head.
  assign match = occ && (id == new_id);
  assign first = match && !found_prev;
  assign found = found_prev || match;

  // Next contents: hold, take the left neighbor, take the new entry or the right neighbor.
  always_comb begin
    id_next  = id;
    pri_next = pri;
    if (cmd.ins && cond) begin
      if (cond_prev) begin
        id_next  = left_id;
        pri_next = left_pri;
      end else begin
        id_next  = new_id;
        pri_next = new_pri;
      end
    end else if (cmd.pop || (cmd.rem && found)) begin
      id_next  = right_id;
      pri_next = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    id  <= id_next;
    pri <= pri_next;
  end

endmodule

FILE: hdl/sorted_priority_process_queue.sv
// Sorted priority queue of process identifiers, head at the first cell.
// Input stream (s_*): one word per operation holding func, proc_id and
// priority_req. Func selects insert, pop head, peek head or remove by id.
// Output stream (m_*): exactly one word per operation holding status,
// out_id, out_priority and the occupancy after the operation.
// Each operation is taken in a single step: every cell compares its entry with
// the request and shifts toward the head or the tail at the accepting edge, and
// the result word, registered at that edge, appears on m_tdata in the next cycle.
// Throughput is one operation per cycle while the receiver takes results;
// the single output register sets that figure.
// When the receiver stalls, the output register holds its word and s_tready
// drops until that word is taken; nothing is lost or repeated.
// Reset empties the queue (occupancy zero) and clears the output valid.
// Insert into a full queue returns status full and leaves the queue as is.
// Pop or peek on an empty queue returns status empty; remove of an absent
// id returns status not found; those results carry zero id and priority.
module sorted_priority_process_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_COUNT      = 32,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // Fields from bit 0 up: func, proc_id, priority_req, zero fill.
  input  logic [8*((2+$clog2(ID_COUNT)+PRIORITY_BITS+7)/8)-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // Fields from bit 0 up: status, out_id, out_priority, occupancy, zero fill.
  output logic [8*((2+$clog2(ID_COUNT)+PRIORITY_BITS+$clog2(QUEUE_DEPTH+1)+7)/8)-1:0] m_tdata
);

  localparam int IW       = $clog2(ID_COUNT);
  localparam int PW       = PRIORITY_BITS;
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_BITS = 2 + IW + PW + CW;
  localparam int OUT_W    = 8 * ((OUT_BITS + 7) / 8);

  logic          accept;
  logic [1:0]    func;
  logic [IW-1:0] raw_id;
  logic [IW-1:0] req_id;
  logic [PW-1:0] req_pri;
  spq_cmd_t      cmd;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH:0]   cond_chain;
  logic [QUEUE_DEPTH:0]   found_chain;
  logic [QUEUE_DEPTH-1:0] first;
  logic [IW-1:0]          cell_id  [QUEUE_DEPTH];
  logic [PW-1:0]          cell_pri [QUEUE_DEPTH];

  logic [IW-1:0] rem_id;
  logic [PW-1:0] rem_pri;

  logic [1:0]    res_status;
  logic [IW-1:0] res_id;
  logic [PW-1:0] res_pri;

  logic [1:0]    status_q;
  logic [IW-1:0] id_q;
  logic [PW-1:0] pri_q;
  logic [CW-1:0] occ_q;

  // Input word unpacking; an id past the last one wraps once.
  assign func    = s_tdata[1:0];
  assign raw_id  = s_tdata[2 +: IW];
  assign req_pri = s_tdata[2+IW +: PW];
  assign req_id  = ({1'b0, raw_id} >= (IW+1)'(ID_COUNT)) ?
                   IW'({1'b0, raw_id} - (IW+1)'(ID_COUNT)) : raw_id;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Command to the cells; insert and pop are gated by the queue's fill level.
  always_comb begin
    cmd.ins = accept && (func == OP_INSERT) && (count != CW'(QUEUE_DEPTH));
    cmd.pop = accept && (func == OP_POP) && (count != '0);
    cmd.rem = accept && (func == OP_REMOVE);
  end

  assign cond_chain[0]  = 1'b0;
  assign found_chain[0] = 1'b0;

  // Chain of cells, each handing entries to its neighbors.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [IW-1:0] left_id;
    logic [PW-1:0] left_pri;
    logic [IW-1:0] right_id;
    logic [PW-1:0] right_pri;

    assign occ[k] = CW'(k) < count;

    if (k == 0) begin : g_head
      assign left_id  = cell_id[k];
      assign left_pri = cell_pri[k];
    end else begin : g_inner_l
      assign left_id  = cell_id[k-1];
      assign left_pri = cell_pri[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign right_id  = cell_id[k];
      assign right_pri = cell_pri[k];
    end else begin : g_inner_r
      assign right_id  = cell_id[k+1];
      assign right_pri = cell_pri[k+1];
    end

    spq_cell #(
      .IW (IW),
      .PW (PW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[k]),
      .new_id     (req_id),
      .new_pri    (req_pri),
      .cond_prev  (cond_chain[k]),
      .found_prev (found_chain[k]),
      .left_id    (left_id),
      .left_pri   (left_pri),
      .right_id   (right_id),
      .right_pri  (right_pri),
      .cond       (cond_chain[k+1]),
      .found      (found_chain[k+1]),
      .first      (first[k]),
      .id         (cell_id[k]),
      .pri        (cell_pri[k])
    );
  end

  // The removed entry is the one cell flagged as the first match.
  always_comb begin
    rem_id  = '0;
    rem_pri = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      rem_id  = rem_id  | (cell_id[k]  & {IW{first[k]}});
      rem_pri = rem_pri | (cell_pri[k] & {PW{first[k]}});
    end
  end

  // Result word and new fill level.
  always_comb begin
    res_status = ST_OK;
    res_id     = '0;
    res_pri    = '0;
    count_next = count;
    case (func)
      OP_INSERT: begin
        if (count == CW'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_id  = cell_id[0];
          res_pri = cell_pri[0];
          if (func == OP_POP) begin
            count_next = count - CW'(1);
          end
        end
      end
      OP_REMOVE: begin
        if (!found_chain[QUEUE_DEPTH]) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_id     = rem_id;
          res_pri    = rem_pri;
          count_next = count - CW'(1);
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Fill level and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= res_status;
      id_q     <= res_id;
      pri_q    <= res_pri;
      occ_q    <= count_next;
    end
  end

  assign m_tdata = OUT_W'({occ_q, pri_q, id_q, status_q});

endmodule
